/* sv/newton_square_root_macros.svh */
// Assertion helpers for the square root block.
`ifndef NEWTON_SQUARE_ROOT_MACROS_SVH
`define NEWTON_SQUARE_ROOT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define NSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nsr assertion failed");
// next-cycle implication
`define NSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nsr assertion failed");
`else
`define NSR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define NSR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/nsr_pkg.sv */
`default_nettype none
package nsr_pkg;
    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DVD_W     = WORD_W + FRAC_BITS;   // dividend / quotient width
    localparam int DIV_STEPS = DVD_W;                // one quotient bit per cycle
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int ITER_W    = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TOL = 1'd1;

    localparam logic [ITER_W-1:0] MAX_ITER_RST = 7'd20;
    localparam logic [WORD_W-1:0] STOP_TOL_RST = 32'd66;
    localparam logic [WORD_W-1:0] EST_ONE      = WORD_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_UPDATE,
        S_SQUARE,
        S_CHECK
    } t_state;

    typedef struct packed {
        logic load;       // capture radicand, estimate = 1.0, count = 0
        logic div_start;  // load divider with radicand << FRAC_BITS
        logic div_step;   // one restoring division step
        logic update;     // estimate = (estimate + quotient) / 2
        logic square;     // register estimate^2
        logic advance;    // count one more iteration
        logic out_load;   // estimate into the output register
    } t_cmd;

    typedef struct packed {
        logic stop;       // limit reached or error below tolerance
    } t_status;
endpackage
`default_nettype wire

/* sv/nsr_datapath.sv */
`default_nettype none
module nsr_datapath
    import nsr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status,
    input  wire logic [WORD_W-1:0]    i_radicand,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]    i_cfg_data,
    output logic      [WORD_W-1:0]    o_root
);
    logic [ITER_W-1:0]   r_max_iter;
    logic [WORD_W-1:0]   r_stop_tol;
    logic [WORD_W-1:0]   r_rad;
    logic [WORD_W-1:0]   r_est;
    logic [ITER_W-1:0]   r_count;
    logic [WORD_W-1:0]   r_rem;
    logic [DVD_W-1:0]    r_dvd;      // dividend shifts out, quotient shifts in
    logic [2*WORD_W-1:0] r_sq;
    logic [WORD_W-1:0]   r_root;

    logic [WORD_W:0]     rem_sh;
    logic                q_bit;
    logic [WORD_W-1:0]   quot;
    logic [WORD_W:0]     sum;
    logic [WORD_W-1:0]   sq_sat;
    logic [WORD_W-1:0]   err;
    logic [ITER_W:0]     count_nx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= MAX_ITER_RST;
            r_stop_tol <= STOP_TOL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_ITER: r_max_iter <= i_cfg_data[ITER_W-1:0];
                CFG_STOP_TOL: r_stop_tol <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // restoring division step
    always_comb begin
        rem_sh = {r_rem, r_dvd[DVD_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_est});
    end

    always_comb begin
        if (r_est == '0) begin
            quot = '0;
        end else if (|r_dvd[DVD_W-1:WORD_W]) begin
            quot = '1;
        end else begin
            quot = r_dvd[WORD_W-1:0];
        end
        sum = {1'b0, r_est} + {1'b0, quot};
    end

    // error check from the registered square
    always_comb begin
        if (|r_sq[2*WORD_W-1:WORD_W+FRAC_BITS]) begin
            sq_sat = '1;
        end else begin
            sq_sat = r_sq[WORD_W+FRAC_BITS-1:FRAC_BITS];
        end
        err      = (r_rad >= sq_sat) ? (r_rad - sq_sat) : (sq_sat - r_rad);
        count_nx = {1'b0, r_count} + (ITER_W+1)'(1);
        o_status.stop = (count_nx >= {1'b0, r_max_iter}) || (err < r_stop_tol);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rad   <= i_radicand;
            r_est   <= EST_ONE;
            r_count <= '0;
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_dvd <= {r_rad, FRAC_BITS'(0)};
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? WORD_W'(rem_sh - {1'b0, r_est}) : rem_sh[WORD_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], q_bit};
        end
        if (i_cmd.update) begin
            r_est <= sum[WORD_W:1];
        end
        if (i_cmd.square) begin
            r_sq <= r_est * r_est;
        end
        if (i_cmd.advance) begin
            r_count <= count_nx[ITER_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_root <= r_est;
        end
    end

    assign o_root = r_root;
endmodule
`default_nettype wire

/* sv/nsr_controller.sv */
`default_nettype none
`include "newton_square_root_macros.svh"
module nsr_controller
    import nsr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_valid,
    output logic         o_s_ready,
    output logic         o_m_valid,
    input  wire logic    i_m_ready,
    output t_cmd         o_cmd,
    input  wire t_status i_status
);
    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        o_cmd    = '0;
        out_free = !r_out_valid || i_m_ready;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.div_start = 1'b1;
                n_step          = '0;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_SQUARE;
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                if (!i_status.stop) begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_SETUP;
                end else if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_m_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_out_valid;

    `NSR_ASSERT_NEXT(a_load_to_setup, i_clk, i_rst_n, o_cmd.load, r_state == S_SETUP)
    `NSR_ASSERT_NEXT(a_out_load_valid, i_clk, i_rst_n, o_cmd.out_load, r_out_valid)
    `NSR_ASSERT_NEXT(a_div_done, i_clk, i_rst_n,
        (r_state == S_DIV) && (r_step == STEP_W'(DIV_STEPS - 1)), r_state == S_UPDATE)
    `NSR_ASSERT_NOW(a_step_range, i_clk, i_rst_n, r_state == S_DIV,
        r_step <= STEP_W'(DIV_STEPS - 1))
endmodule
`default_nettype wire

/* sv/newton_square_root.sv */
// Each Newton iteration runs setup, 48 division steps, update, squaring and
// check; after the last check the root is loaded into the output register once
// that register is free. The next radicand is taken only once the result sits
// in the output register, so the single bit-serial divider works on one radicand
// at a time. Reset (synchronous, active low):
// controller idle, output empty, max_iterations = 20, stop_tolerance = 66.
`default_nettype none
module newton_square_root
    import nsr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // radicand input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [WORD_W-1:0]    s_axis_tdata,   // [31:0] radicand
    // root output stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [WORD_W-1:0]    m_axis_tdata,   // [31:0] root
    // register writes: index 0 max_iterations, 1 stop_tolerance
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]    i_cfg_data
);
    t_cmd    cmd;
    t_status status;

    // registers are plain flops, a write is always taken
    assign o_cfg_ready = 1'b1;

    // sequencer: one word in, iterate, one word out
    nsr_controller u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (cmd),
        .i_status  (status)
    );

    // estimate, divider, squarer, error compare and output register
    nsr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_radicand  (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_root      (m_axis_tdata)
    );
endmodule
`default_nettype wire

/* tb/tb_newton_square_root.sv */
`default_nettype none
module tb_newton_square_root;
    import nsr_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [WORD_W-1:0] s_axis_tdata  = '0;     // [31:0] radicand
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [WORD_W-1:0] m_axis_tdata;           // [31:0] root
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]    i_cfg_data  = '0;

    newton_square_root DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the two registers, as of the last completed write.
    // Reset values match the block's reset.
    // ------------------------------------------------------------------
    logic [ITER_W-1:0] limit_cfg = MAX_ITER_RST;
    logic [WORD_W-1:0] tol_cfg   = STOP_TOL_RST;

    logic [WORD_W-1:0] root_expect_q [$];   // roots still owed by the block
    int unsigned       fail_count     = 0;
    int unsigned       src_gap_pct    = 0;   // chance per word the sender idles
    int unsigned       sink_stall_pct = 0;   // chance per cycle the receiver stalls

    // ------------------------------------------------------------------
    // Heron iteration in Q16.16, bit exact:
    //   quotient = sat32((rad << FRAC_BITS) / est), zero when est is zero
    //   est      = (est + quotient) >> 1, sum in 33 bits
    //   square   = sat32(est * est >> FRAC_BITS)
    //   error    = |rad - square|
    // At least one pass; stop on the limit or when error < tolerance.
    // ------------------------------------------------------------------
    function automatic logic [WORD_W-1:0] heron_root(input logic [WORD_W-1:0] rad,
                                                     input logic [ITER_W-1:0] limit,
                                                     input logic [WORD_W-1:0] tol);
        logic [WORD_W-1:0]   est;
        logic [2*WORD_W-1:0] quo;
        logic [2*WORD_W-1:0] prod;
        logic [WORD_W-1:0]   sq;
        logic [WORD_W-1:0]   err;
        int unsigned         passes;
        est    = EST_ONE;
        passes = 0;
        do begin
            quo = '0;
            if (est != '0)
                quo = ((2*WORD_W)'(rad) << FRAC_BITS) / (2*WORD_W)'(est);
            if (quo > (2*WORD_W)'(32'hFFFF_FFFF))
                quo = (2*WORD_W)'(32'hFFFF_FFFF);
            est  = WORD_W'(((2*WORD_W)'(est) + quo) >> 1);
            prod = ((2*WORD_W)'(est) * (2*WORD_W)'(est)) >> FRAC_BITS;
            sq   = (prod > (2*WORD_W)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : prod[WORD_W-1:0];
            err  = (rad >= sq) ? rad - sq : sq - rad;
            passes++;
        end while (passes < limit && err >= tol);
        return est;
    endfunction

    // ------------------------------------------------------------------
    // Directed rows, run at the reset settings (limit 20, tolerance 66).
    // Where the root is typed in, it is easy to follow by hand:
    //   0   -> estimate halves 1.0, 0.5, ... until 1/32, whose square 64 < 66
    //   1.0 -> the first pass lands exactly on 1.0
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [WORD_W-1:0] rad;
        logic              known;
        logic [WORD_W-1:0] root;
    } t_root_case;

    t_root_case directed_rows [19] = '{
        '{32'h0000_0000, 1'b1, 32'h0000_0800},
        '{32'h0001_0000, 1'b1, 32'h0001_0000},
        '{32'h0000_0001, 1'b0, 32'h0},          // smallest nonzero
        '{32'h0000_0002, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 1'b0, 32'h0},          // largest: square saturates early
        '{32'hFFFF_0000, 1'b0, 32'h0},
        '{32'h8000_0000, 1'b0, 32'h0},
        '{32'h7FFF_FFFF, 1'b0, 32'h0},
        '{32'h0004_0000, 1'b0, 32'h0},          // 4.0
        '{32'h0009_0000, 1'b0, 32'h0},          // 9.0
        '{32'h0019_0000, 1'b0, 32'h0},          // 25.0
        '{32'h0000_8000, 1'b0, 32'h0},          // 0.5
        '{32'h0001_0001, 1'b0, 32'h0},
        '{32'h0000_FFFF, 1'b0, 32'h0},
        '{32'h0000_0100, 1'b0, 32'h0},
        '{32'h0100_0000, 1'b0, 32'h0},
        '{32'h00A0_0000, 1'b0, 32'h0},
        '{32'h5555_5555, 1'b0, 32'h0},
        '{32'hAAAA_AAAA, 1'b0, 32'h0}
    };

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Present one radicand; the root it owes is queued once the word is taken.
    task automatic send_radicand(input logic [WORD_W-1:0] rad,
                                 input logic [WORD_W-1:0] root_want);
        while ($urandom_range(99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rad;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        root_expect_q.push_back(root_want);
    endtask

    // Hold off the sender until every owed root has come back.
    task automatic drain_roots();
        s_axis_tvalid <= 1'b0;
        while (root_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
    endtask

    // Both registers, back to back, with the block idle. Upper bits of the
    // limit word are random: only the low 7 bits count.
    task automatic cfg_apply(input logic [ITER_W-1:0] limit, input logic [WORD_W-1:0] tol);
        logic [WORD_W-1:0] limit_word;
        limit_word             = $urandom();
        limit_word[ITER_W-1:0] = limit;
        drain_roots();
        cfg_write(CFG_MAX_ITER, limit_word);
        cfg_write(CFG_STOP_TOL, tol);
        i_cfg_valid <= 1'b0;
        limit_cfg = limit;
        tol_cfg   = tol;
    endtask

    // Mix of full-range values, small values, exact squares and powers of two.
    function automatic logic [WORD_W-1:0] random_radicand();
        logic [WORD_W-1:0] k;
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom() >> $urandom_range(31);
            2: begin
                k = $urandom_range(255);
                return (k * k) << FRAC_BITS;        // root is exactly k
            end
            default: return 32'h1 << $urandom_range(31);
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] random_tolerance();
        case ($urandom_range(3))
            0: return '0;
            1: return $urandom();
            default: return $urandom() >> $urandom_range(31);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: check every root taken, then pick next cycle's ready.
    // Values are sampled as they were just before the edge.
    // ------------------------------------------------------------------
    task automatic check_root(input logic [WORD_W-1:0] got);
        logic [WORD_W-1:0] want;
        if (root_expect_q.size() == 0) begin
            $error("root: expected none, actual %h", got);
            fail_count++;
        end else begin
            want = root_expect_q.pop_front();
            if (got !== want) begin
                $error("root: expected %h, actual %h", want, got);
                fail_count++;
            end
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                check_root(m_axis_tdata);
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    //   directed rows at reset settings, then phases of random radicands.
    //   Early phases hit the register extremes: limit 1, limit 127 (few
    //   words, slow), limit 0 (one pass), limit 64, zero tolerance, all-ones
    //   tolerance. Each phase opens with radicand 0 (estimate decays to
    //   zero under zero tolerance) and all-ones.
    //   Idling: sender 16% / receiver 73% first, then swapped, then none.
    // ------------------------------------------------------------------
    initial begin
        int unsigned       sent;
        int unsigned       phase_words;
        logic [ITER_W-1:0] next_limit;
        logic [WORD_W-1:0] next_tol;
        logic [WORD_W-1:0] rad;
        sent = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_gap_pct    = 16;
        sink_stall_pct = 73;
        foreach (directed_rows[r]) begin
            send_radicand(directed_rows[r].rad,
                          directed_rows[r].known ? directed_rows[r].root
                                                 : heron_root(directed_rows[r].rad,
                                                              limit_cfg, tol_cfg));
        end

        for (int phase = 0; phase < 14; phase++) begin
            case (phase)
                0: begin next_limit = 7'd1;   next_tol = '0; phase_words = 60; end
                1: begin next_limit = 7'd127; next_tol = '0; phase_words = 4;  end
                2: begin next_limit = 7'd0;   next_tol = '1; phase_words = 60; end
                3: begin next_limit = 7'd64;  next_tol = '0; phase_words = 4;  end
                4: begin
                    next_limit  = MAX_ITER_RST;
                    next_tol    = STOP_TOL_RST;
                    phase_words = 30;
                end
                default: begin
                    next_limit  = ITER_W'($urandom_range(1, 8));
                    next_tol    = random_tolerance();
                    phase_words = 50;
                end
            endcase
            cfg_apply(next_limit, next_tol);

            for (int k = 0; k < phase_words; k++) begin
                if (sent == 200) begin
                    src_gap_pct    = 73;
                    sink_stall_pct = 16;
                end else if (sent == 400) begin
                    src_gap_pct    = 0;
                    sink_stall_pct = 0;
                end
                rad = (k == 0) ? '0 : (k == 1) ? '1 : random_radicand();
                send_radicand(rad, heron_root(rad, limit_cfg, tol_cfg));
                sent++;
                // occasional full stop mid-phase
                if (k != phase_words - 1 && $urandom_range(63) == 0)
                    drain_roots();
            end
        end

        // wait out the last root, then watch for strays
        drain_roots();
        repeat (150) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS newton_square_root");
        else
            $display("FAIL newton_square_root");
        $finish;
    end

    // Watchdog: ends the run with a failure if it hangs.
    initial begin
        #40_000_000;
        $display("FAIL newton_square_root");
        $finish;
    end
endmodule
`default_nettype wire

/* newton_square_root.f */
+incdir+sv
sv/nsr_pkg.sv
sv/nsr_datapath.sv
sv/nsr_controller.sv
sv/newton_square_root.sv
tb/tb_newton_square_root.sv
